[src/vjrb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vjrb_pkg
// Shared types and constants for the voice jitter reorder buffer.
// ----------------------------------------------------------------------------
package vjrb_pkg;
  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam logic [15:0] HALF = 16'h8000;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_LOSS = 2'd2;
  localparam logic [1:0] KIND_END = 2'd3;

  localparam logic [1:0] REG_MAX_REORDER = 2'd0;
  localparam logic [1:0] REG_PREBUF = 2'd1;
  localparam logic [1:0] REG_MAX_LOSS = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [15:0] seq_id;
    logic        talk_start;
    logic        talk_end;
    logic [31:0] payload_handle;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_seq;
    logic [31:0] out_handle;
    logic        out_talk_start;
    logic        stream_start;
    logic        has_recovery;
  } out_req_t;

  // Scan unit results, one pass over all slots.
  typedef struct packed {
    logic             hit_found;     // slot equal to key
    logic [IDX_W-1:0] hit_idx;
    logic             nxt_found;     // slot equal to key+1
    logic [IDX_W-1:0] nxt_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [CNT_W-1:0] count;
    logic             ahead_found;   // any slot strictly ahead of expected
    logic             best_found;    // any slot ahead or equal
    logic [15:0]      best_dist;
    logic [IDX_W-1:0] best_idx;
    logic [15:0]      low_seq;
    logic [IDX_W-1:0] low_idx;
  } scan_t;
endpackage

[src/vjrb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vjrb_in_if / vjrb_out_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface vjrb_in_if;
  logic              valid;
  logic              ready;
  vjrb_pkg::in_req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface vjrb_out_if;
  logic               valid;
  logic               ready;
  vjrb_pkg::out_req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[src/vjrb_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vjrb_scan
// Shared compare unit: looks at one slot per cycle while step is high and accumulates matches.
// ----------------------------------------------------------------------------
module vjrb_scan (
  input  logic                       clk,
  input  logic                       start,
  input  logic                       step,
  input  logic [vjrb_pkg::IDX_W-1:0] idx,
  input  logic                       valid,
  input  logic [15:0]                seq,
  input  logic [15:0]                key,
  input  logic [15:0]                exp_seq,
  output vjrb_pkg::scan_t            res
);
  vjrb_pkg::scan_t res_r, res_nxt;
  logic [15:0] d;
  logic [15:0] key1;

  assign d    = seq - exp_seq;
  assign key1 = key + 16'd1;
  assign res  = res_r;

  always_comb begin
    res_nxt = res_r;
    if (start) begin
      res_nxt = '0;
      res_nxt.low_seq = 16'hFFFF;
    end else if (step) begin
      if (!valid) begin
        if (!res_r.free_found) begin
          res_nxt.free_found = 1'b1;
          res_nxt.free_idx   = idx;
        end
      end else begin
        res_nxt.count = res_r.count + 1'b1;
        if (seq == key && !res_r.hit_found) begin
          res_nxt.hit_found = 1'b1;
          res_nxt.hit_idx   = idx;
        end
        if (seq == key1 && !res_r.nxt_found) begin
          res_nxt.nxt_found = 1'b1;
          res_nxt.nxt_idx   = idx;
        end
        if (d < vjrb_pkg::HALF) begin
          if (d != 16'd0) res_nxt.ahead_found = 1'b1;
          if (!res_r.best_found || d > res_r.best_dist) begin
            res_nxt.best_found = 1'b1;
            res_nxt.best_dist  = d;
            res_nxt.best_idx   = idx;
          end
        end
        if (seq < res_r.low_seq || (idx == '0)) begin
          res_nxt.low_seq = seq;
          res_nxt.low_idx = idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end
endmodule

[src/voice_jitter_reorder_buffer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_jitter_reorder_buffer_top
// Reorder buffer for voice frames keyed by wrapping 16-bit sequence numbers.
// ----------------------------------------------------------------------------
// Usage:
//   in  channel: one request per frame push (mode 0) or playback pull (mode 1).
//   out channel: one result per pull; pushes produce no result.
//   cfg port   : APB-style writes/reads of max_reorder_distance (0x0),
//                prebuffer_count (0x4) and max_losses_in_row (0x8).
// Timing:
//   Frame pushes and pulls scan the 16 slots through one shared compare unit,
//   one slot per cycle. A frame push goes through prelude, scan and update
//   before the next accept; a stale frame is dropped in the prelude. A pull
//   goes through scan and S_DONE, then S_OUT registers its result onto out;
//   the next request is accepted once the result is taken. An end-mark push
//   is handled in the accept cycle, so in_ready stays high for the next one.
//   in_ready is low while a request is being worked on.
// Reset:
//   rst_n (sync, active low) clears stream state and slot valid bits and
//   loads register defaults 32 / 3 / 5. No clearing pass is needed.
// Stall:
//   A pull result sits in the output register until taken; the next request
//   is not accepted until then, so a stall on out holds back the in channel.
// ----------------------------------------------------------------------------
module voice_jitter_reorder_buffer_top (
  input  logic        clk,
  input  logic        rst_n,
  vjrb_in_if.sink     in_ch,
  vjrb_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int IW = vjrb_pkg::IDX_W;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SCAN2 = 3'd2;   // push prelude before the scan
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  // config registers
  logic [14:0] max_reorder_r;
  logic [4:0]  prebuf_r;
  logic [7:0]  max_loss_r;
  logic [1:0]  reg_idx;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;
  always_comb begin
    case (reg_idx)
      vjrb_pkg::REG_MAX_REORDER: cfg_prdata = {17'd0, max_reorder_r};
      vjrb_pkg::REG_PREBUF:      cfg_prdata = {27'd0, prebuf_r};
      vjrb_pkg::REG_MAX_LOSS:    cfg_prdata = {24'd0, max_loss_r};
      default:                   cfg_prdata = 32'd0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_reorder_r <= 15'd32;
      prebuf_r      <= 5'd3;
      max_loss_r    <= 8'd5;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (reg_idx)
        vjrb_pkg::REG_MAX_REORDER: max_reorder_r <= cfg_pwdata[14:0];
        vjrb_pkg::REG_PREBUF:      prebuf_r      <= cfg_pwdata[4:0];
        vjrb_pkg::REG_MAX_LOSS:    max_loss_r    <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // slot store
  logic [vjrb_pkg::DEPTH-1:0] slot_valid_r;
  logic [15:0] slot_seq_r [vjrb_pkg::DEPTH];
  logic [31:0] slot_handle_r [vjrb_pkg::DEPTH];
  logic        slot_ts_r [vjrb_pkg::DEPTH];

  // stream state
  logic        exp_valid_r, end_valid_r, started_r, first_r;
  logic [15:0] exp_seq_r, end_seq_r;
  logic [7:0]  loss_r;
  logic [2:0]  state_r;
  logic [IW:0] cnt_r;
  vjrb_pkg::in_req_t req_r;
  vjrb_pkg::out_req_t res_r;
  logic        out_valid_r;

  logic [IW-1:0] sidx;
  assign sidx = cnt_r[IW-1:0];
  logic scan_start, scan_step;
  vjrb_pkg::scan_t sc;

  assign scan_start = (state_r == S_IDLE) || (state_r == S_SCAN2 && cnt_r == '0);
  assign scan_step  = (state_r == S_SCAN || state_r == S_SCAN2) && !cnt_r[IW];

  vjrb_scan u_scan (
    .clk(clk), .start(scan_start), .step(scan_step), .idx(sidx),
    .valid(slot_valid_r[sidx]), .seq(slot_seq_r[sidx]),
    .key(req_r.mode ? exp_seq_r : req_r.seq_id), .exp_seq(exp_seq_r), .res(sc)
  );

  assign in_ch.ready   = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.data   = res_r;

  logic [15:0] fwd, back, d_end;
  logic        rebase_ok;
  assign fwd   = req_r.seq_id - exp_seq_r;
  assign back  = exp_seq_r - req_r.seq_id;
  assign d_end = end_seq_r - exp_seq_r;
  // behind, but a talk start close enough before playback: move expected back
  assign rebase_ok = !started_r && req_r.talk_start && back <= {1'b0, max_reorder_r};

  // pull decision from the finished scan
  vjrb_pkg::out_req_t pull_res;
  logic pull_reset, pull_start;
  always_comb begin
    pull_res   = '0;
    pull_reset = 1'b0;
    pull_start = 1'b0;
    if (exp_valid_r) begin
      if (end_valid_r && end_seq_r == exp_seq_r) begin
        pull_res.kind = vjrb_pkg::KIND_END;
        pull_reset    = 1'b1;
      end else if (!started_r && ({1'b0, sc.count} < {1'b0, prebuf_r})
                   && !end_valid_r) begin
        // still prebuffering: nothing
      end else if (sc.hit_found) begin
        pull_start              = 1'b1;
        pull_res.kind           = vjrb_pkg::KIND_FRAME;
        pull_res.out_seq        = slot_seq_r[sc.hit_idx];
        pull_res.out_handle     = slot_handle_r[sc.hit_idx];
        pull_res.out_talk_start = slot_ts_r[sc.hit_idx];
        pull_res.stream_start   = first_r;
      end else if (!(sc.ahead_found ||
                     (end_valid_r && d_end != 16'd0 && d_end < vjrb_pkg::HALF))) begin
        pull_start = 1'b1;       // nothing ahead: no advance
      end else if (loss_r < max_loss_r) begin
        pull_start    = 1'b1;
        pull_res.kind = vjrb_pkg::KIND_LOSS;
        if (sc.nxt_found) begin
          pull_res.out_seq        = slot_seq_r[sc.nxt_idx];
          pull_res.out_handle     = slot_handle_r[sc.nxt_idx];
          pull_res.out_talk_start = slot_ts_r[sc.nxt_idx];
          pull_res.has_recovery   = 1'b1;
        end
      end else begin
        pull_res.kind = vjrb_pkg::KIND_END;
        pull_reset    = 1'b1;
      end
    end
  end

  // control FSM. Push prelude: decides whether the pushed frame is kept and
  // settles a rebase/reset before the scan (expected number changes the victim).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      exp_valid_r  <= 1'b0;
      end_valid_r  <= 1'b0;
      started_r    <= 1'b0;
      first_r      <= 1'b0;
      exp_seq_r    <= 16'd0;
      end_seq_r    <= 16'd0;
      loss_r       <= 8'd0;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (in_ch.valid && in_ch.ready) begin
            req_r <= in_ch.data;
            if (!in_ch.data.mode) begin
              if (in_ch.data.talk_end) begin
                if (!exp_valid_r) begin
                  exp_valid_r <= 1'b1;
                  exp_seq_r   <= in_ch.data.seq_id;
                  first_r     <= 1'b1;
                  end_valid_r <= 1'b1;
                  end_seq_r   <= in_ch.data.seq_id;
                end else if ((in_ch.data.seq_id - exp_seq_r) < vjrb_pkg::HALF) begin
                  end_valid_r <= 1'b1;
                  end_seq_r   <= in_ch.data.seq_id;
                end
              end else begin
                state_r <= S_SCAN2;
              end
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN2: begin
          // settle expected number before scanning
          if (!exp_valid_r) begin
            exp_valid_r <= 1'b1;
            exp_seq_r   <= req_r.seq_id;
            first_r     <= 1'b1;
            state_r     <= S_SCAN;
          end else if (fwd >= vjrb_pkg::HALF) begin
            if (rebase_ok) begin
              exp_seq_r <= req_r.seq_id;
              state_r   <= S_SCAN;
            end else begin
              state_r   <= S_IDLE;   // stale, dropped
            end
          end else if (fwd > {1'b0, max_reorder_r}) begin
            exp_valid_r  <= 1'b1;
            exp_seq_r    <= req_r.seq_id;
            first_r      <= 1'b1;
            end_valid_r  <= 1'b0;
            slot_valid_r <= '0;
            loss_r       <= 8'd0;
            started_r    <= 1'b0;
            state_r      <= S_SCAN;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_r[IW]) state_r <= S_DONE;
          else cnt_r <= cnt_r + 1'b1;
        end
        S_DONE: begin
          if (!req_r.mode) begin
            state_r <= S_IDLE;
            if (!sc.hit_found) begin
              if (sc.free_found) begin
                slot_valid_r[sc.free_idx]  <= 1'b1;
                slot_seq_r[sc.free_idx]    <= req_r.seq_id;
                slot_handle_r[sc.free_idx] <= req_r.payload_handle;
                slot_ts_r[sc.free_idx]     <= req_r.talk_start;
              end else begin
                // new frame as candidate: ahead distance fwd, seq seq_id
                if ((fwd < vjrb_pkg::HALF && (!sc.best_found || fwd > sc.best_dist)) ||
                    (!sc.best_found && fwd >= vjrb_pkg::HALF && req_r.seq_id < sc.low_seq)) begin
                  // new frame dropped
                end else if (sc.best_found) begin
                  slot_seq_r[sc.best_idx]    <= req_r.seq_id;
                  slot_handle_r[sc.best_idx] <= req_r.payload_handle;
                  slot_ts_r[sc.best_idx]     <= req_r.talk_start;
                end else begin
                  slot_seq_r[sc.low_idx]    <= req_r.seq_id;
                  slot_handle_r[sc.low_idx] <= req_r.payload_handle;
                  slot_ts_r[sc.low_idx]     <= req_r.talk_start;
                end
              end
            end
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          res_r       <= pull_res;
          if (pull_reset) begin
            exp_valid_r <= 1'b0; end_valid_r <= 1'b0; slot_valid_r <= '0;
            loss_r <= 8'd0; started_r <= 1'b0; first_r <= 1'b0;
          end else begin
            if (pull_start) started_r <= 1'b1;
            if (pull_res.kind == vjrb_pkg::KIND_FRAME) begin
              slot_valid_r[sc.hit_idx] <= 1'b0;
              loss_r    <= 8'd0;
              first_r   <= 1'b0;
              exp_seq_r <= exp_seq_r + 16'd1;
            end else if (pull_res.kind == vjrb_pkg::KIND_LOSS) begin
              loss_r    <= loss_r + 8'd1;
              first_r   <= 1'b0;
              exp_seq_r <= exp_seq_r + 16'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
